FILE: hw/rtl/rpe_pkg.sv
// Shared types, widths and the rounding function for the rotary position embedding core.
// No dependencies; imported by rpe_rotate and rotary_position_embed_core.
`timescale 1ns / 1ps

package rpe_pkg;

    localparam int POS_W       = 10;
    localparam int PAIR_W      = 6;
    localparam int ADDR_W      = POS_W + PAIR_W;
    localparam int TABLE_DEPTH = 1 << ADDR_W;
    localparam int DATA_W      = 16;
    localparam int TRIG_W      = 16;
    localparam int PROD_W      = DATA_W + TRIG_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int FRAC_SHIFT  = 14;
    localparam int ROUND_HALF  = 1 << (FRAC_SHIFT - 1);
    localparam int ENTRY_W     = 2 * TRIG_W;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_ROTATE = 1'b1
    } command_t;

    // Control that travels alongside a rotate request through the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctrl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } round_res_t;

    // Rounds a Q12.22 sum to Q8.8 (half up) and clips it to the 16-bit range.
    function automatic round_res_t round_sat(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0]            biased;
        logic signed [SUM_W-FRAC_SHIFT-1:0] shifted;
        round_res_t                         res;
        biased  = sum + SUM_W'(ROUND_HALF);
        shifted = biased[SUM_W-1:FRAC_SHIFT];
        if (shifted > (SUM_W-FRAC_SHIFT)'(32767)) begin
            res.value = 16'sh7FFF;
            res.sat   = 1'b1;
        end
        else if (shifted < -(SUM_W-FRAC_SHIFT)'(32768)) begin
            res.value = 16'sh8000;
            res.sat   = 1'b1;
        end
        else begin
            res.value = shifted[DATA_W-1:0];
            res.sat   = 1'b0;
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/rpe_rotate.sv
// Two-stage rotation datapath: a product stage, then sum, rounding and the result register.
// Depends on rpe_pkg.
`timescale 1ns / 1ps

module rpe_rotate
    import rpe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  stage_ctrl_t              ctrl,
    input  logic signed [TRIG_W-1:0] cos_v,
    input  logic signed [TRIG_W-1:0] sin_v,
    input  logic signed [DATA_W-1:0] qa,
    input  logic signed [DATA_W-1:0] qb,
    input  logic signed [DATA_W-1:0] ka,
    input  logic signed [DATA_W-1:0] kb,
    output logic                     res_valid,
    output logic signed [DATA_W-1:0] q_first_out,
    output logic signed [DATA_W-1:0] q_second_out,
    output logic signed [DATA_W-1:0] k_first_out,
    output logic signed [DATA_W-1:0] k_second_out,
    output logic                     last_out,
    output logic                     saturated
);

    stage_ctrl_t              p_ctrl_reg;
    stage_ctrl_t              p_ctrl_next;
    stage_ctrl_t              o_ctrl_reg;
    stage_ctrl_t              o_ctrl_next;
    logic signed [PROD_W-1:0] qa_c_reg, qb_s_reg, qb_c_reg, qa_s_reg;
    logic signed [PROD_W-1:0] ka_c_reg, kb_s_reg, kb_c_reg, ka_s_reg;
    logic signed [DATA_W-1:0] q1_reg, q2_reg, k1_reg, k2_reg;
    logic                     sat_reg;
    round_res_t               r_q1, r_q2, r_k1, r_k2;

    assign p_ctrl_next = advance ? ctrl : p_ctrl_reg;
    assign o_ctrl_next = advance ? p_ctrl_reg : o_ctrl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_ctrl_reg <= '0;
            o_ctrl_reg <= '0;
        end
        else
        begin
            p_ctrl_reg <= p_ctrl_next;
            o_ctrl_reg <= o_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            qa_c_reg <= qa * cos_v;
            qb_s_reg <= qb * sin_v;
            qb_c_reg <= qb * cos_v;
            qa_s_reg <= qa * sin_v;
            ka_c_reg <= ka * cos_v;
            kb_s_reg <= kb * sin_v;
            kb_c_reg <= kb * cos_v;
            ka_s_reg <= ka * sin_v;
        end
    end

    always_comb
    begin
        r_q1 = round_sat(SUM_W'(qa_c_reg) - SUM_W'(qb_s_reg));
        r_q2 = round_sat(SUM_W'(qb_c_reg) + SUM_W'(qa_s_reg));
        r_k1 = round_sat(SUM_W'(ka_c_reg) - SUM_W'(kb_s_reg));
        r_k2 = round_sat(SUM_W'(kb_c_reg) + SUM_W'(ka_s_reg));
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q1_reg  <= r_q1.value;
            q2_reg  <= r_q2.value;
            k1_reg  <= r_k1.value;
            k2_reg  <= r_k2.value;
            sat_reg <= r_q1.sat | r_q2.sat | r_k1.sat | r_k2.sat;
        end
    end

    assign res_valid    = o_ctrl_reg.valid;
    assign last_out     = o_ctrl_reg.last;
    assign q_first_out  = q1_reg;
    assign q_second_out = q2_reg;
    assign k_first_out  = k1_reg;
    assign k_second_out = k2_reg;
    assign saturated    = sat_reg;

endmodule

FILE: hw/rtl/rotary_position_embed_core.sv
// Top level of the rotary position embedding core: cos/sin table memory and pipeline control.
// Depends on rpe_pkg and rpe_rotate.
//
//  Channel   Handshake              Payload
//  request   req_valid/req_stall    command, position, pair_index, cos_value, sin_value,
//                                   q_first, q_second, k_first, k_second, last_pair
//  result    res_valid/res_stall    q_first_out, q_second_out, k_first_out, k_second_out,
//                                   last_out, saturated
//
// One request is taken every cycle while req_stall is low; a rotate's result passes through
// the table read, products, then sum, rounding and the result register.
// A load writes the table at its acceptance edge, so a rotate in the very next cycle reads it.
// The whole pipeline holds while a result waits under res_stall; req_stall follows it.
// Reset clears the pipeline valid and last bits only; the table is undefined until loaded.
`timescale 1ns / 1ps

module rotary_position_embed_core
    import rpe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic                     command,
    input  logic [POS_W-1:0]         position,
    input  logic [PAIR_W-1:0]        pair_index,
    input  logic signed [TRIG_W-1:0] cos_value,
    input  logic signed [TRIG_W-1:0] sin_value,
    input  logic signed [DATA_W-1:0] q_first,
    input  logic signed [DATA_W-1:0] q_second,
    input  logic signed [DATA_W-1:0] k_first,
    input  logic signed [DATA_W-1:0] k_second,
    input  logic                     last_pair,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic signed [DATA_W-1:0] q_first_out,
    output logic signed [DATA_W-1:0] q_second_out,
    output logic signed [DATA_W-1:0] k_first_out,
    output logic signed [DATA_W-1:0] k_second_out,
    output logic                     last_out,
    output logic                     saturated
);

    logic [ENTRY_W-1:0]       table_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]       rd_data_reg;
    logic [ADDR_W-1:0]        addr;
    logic                     advance;
    logic                     accept;
    logic                     wr_en;
    logic                     rd_en;
    stage_ctrl_t              s1_ctrl_reg;
    stage_ctrl_t              s1_ctrl_next;
    logic signed [DATA_W-1:0] qa_reg, qb_reg, ka_reg, kb_reg;

    assign advance   = !(res_valid && res_stall);
    assign req_stall = !advance;
    assign accept    = req_valid && advance;
    assign addr      = {position, pair_index};
    assign wr_en     = accept && (command == CMD_LOAD);
    assign rd_en     = accept && (command == CMD_ROTATE);

    // Entry layout: sine in the upper half, cosine in the lower half.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[addr] <= {sin_value, cos_value};
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[addr];
        end
    end

    always_comb
    begin
        s1_ctrl_next = s1_ctrl_reg;
        if (advance)
        begin
            s1_ctrl_next.valid = rd_en;
            s1_ctrl_next.last  = last_pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
        end
        else
        begin
            s1_ctrl_reg <= s1_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            qa_reg <= q_first;
            qb_reg <= q_second;
            ka_reg <= k_first;
            kb_reg <= k_second;
        end
    end

    rpe_rotate u_rotate (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .ctrl         (s1_ctrl_reg),
        .cos_v        (rd_data_reg[TRIG_W-1:0]),
        .sin_v        (rd_data_reg[ENTRY_W-1:TRIG_W]),
        .qa           (qa_reg),
        .qb           (qb_reg),
        .ka           (ka_reg),
        .kb           (kb_reg),
        .res_valid    (res_valid),
        .q_first_out  (q_first_out),
        .q_second_out (q_second_out),
        .k_first_out  (k_first_out),
        .k_second_out (k_second_out),
        .last_out     (last_out),
        .saturated    (saturated)
    );

    a_rotate_enters: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> s1_ctrl_reg.valid)
        else $error("accepted rotate did not enter the read stage");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> !s1_ctrl_reg.valid)
        else $error("load request produced a pipeline entry");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_ctrl_reg.valid && req_stall |=> s1_ctrl_reg.valid && $stable(rd_data_reg))
        else $error("read stage changed while the pipeline was held");

endmodule
